>>> src/morse_text_encoder_unit_assert.svh
// Assertion helpers used by the RTL file mte_serialize.sv.
`ifndef MORSE_TEXT_ENCODER_UNIT_ASSERT_SVH
`define MORSE_TEXT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define MTE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("morse encoder assertion failed");

// Next-cycle implication, checked on i_clk, off during reset.
`define MTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("morse encoder assertion failed");

`endif

>>> src/mte_pkg.sv
`default_nettype none

package mte_pkg;

    localparam int MaxSegs = 10;

    localparam logic [1:0] GAP_NONE   = 2'd0;
    localparam logic [1:0] GAP_LETTER = 2'd1;
    localparam logic [1:0] GAP_WORD   = 2'd2;

    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_Z     = 8'h7a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [2:0] UNITS_DOT        = 3'd1;
    localparam logic [2:0] UNITS_DASH       = 3'd3;
    localparam logic [2:0] UNITS_SYM_GAP    = 3'd1;
    localparam logic [2:0] UNITS_LETTER_GAP = 3'd2;
    localparam logic [2:0] UNITS_WORD_GAP   = 3'd6;
    localparam logic [2:0] UNITS_END_GAP    = 3'd7;

    typedef struct packed {
        logic       level;
        logic [2:0] units;
        logic       fin;
    } t_seg;

    typedef struct packed {
        logic [3:0]               cnt;
        t_seg [MaxSegs-1:0]       seg;
    } t_seg_list;

    // dash[i] set when symbol i is a dash
    typedef struct packed {
        logic [2:0] len;
        logic [3:0] dash;
    } t_code;

    function automatic t_code morse_code(input logic [4:0] idx);
        t_code c;
        unique case (idx)
            5'd0:    c = '{3'd2, 4'b0010};
            5'd1:    c = '{3'd4, 4'b0001};
            5'd2:    c = '{3'd4, 4'b0101};
            5'd3:    c = '{3'd3, 4'b0001};
            5'd4:    c = '{3'd1, 4'b0000};
            5'd5:    c = '{3'd4, 4'b0100};
            5'd6:    c = '{3'd3, 4'b0011};
            5'd7:    c = '{3'd4, 4'b0000};
            5'd8:    c = '{3'd2, 4'b0000};
            5'd9:    c = '{3'd4, 4'b1110};
            5'd10:   c = '{3'd3, 4'b0101};
            5'd11:   c = '{3'd4, 4'b0010};
            5'd12:   c = '{3'd2, 4'b0011};
            5'd13:   c = '{3'd2, 4'b0001};
            5'd14:   c = '{3'd3, 4'b0111};
            5'd15:   c = '{3'd4, 4'b0110};
            5'd16:   c = '{3'd4, 4'b1011};
            5'd17:   c = '{3'd3, 4'b0010};
            5'd18:   c = '{3'd3, 4'b0000};
            5'd19:   c = '{3'd1, 4'b0001};
            5'd20:   c = '{3'd3, 4'b0100};
            5'd21:   c = '{3'd4, 4'b1000};
            5'd22:   c = '{3'd3, 4'b0110};
            5'd23:   c = '{3'd4, 4'b1001};
            5'd24:   c = '{3'd4, 4'b1101};
            5'd25:   c = '{3'd4, 4'b0011};
            default: c = '{3'd0, 4'b0000};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/mte_decode.sv
`default_nettype none

module mte_decode (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_char_code,
    input  wire logic                 i_is_last,
    input  wire logic                 i_load_ok,
    output logic                      o_load,
    output mte_pkg::t_seg_list        o_list
);

    logic                r_valid;
    logic [7:0]          r_char;
    logic                r_last;
    logic [1:0]          r_gap;
    logic [1:0]          n_gap;

    logic                is_letter;
    logic                is_space;
    logic [7:0]          char_off;
    mte_pkg::t_code      code;
    logic                lead;
    logic [1:0]          gap_mid;
    logic                closing;
    logic [3:0]          sym_n;
    logic [3:0]          m;
    logic                take;

    always_comb begin
        is_letter = (r_char >= mte_pkg::CHAR_A) && (r_char <= mte_pkg::CHAR_Z);
        is_space  = (r_char == mte_pkg::CHAR_SPACE);
        char_off  = r_char - mte_pkg::CHAR_A;
        code      = mte_pkg::morse_code(char_off[4:0]);
        lead      = is_letter && (r_gap != mte_pkg::GAP_NONE);
        if (is_letter) begin
            gap_mid = mte_pkg::GAP_LETTER;
        end else if (is_space && (r_gap != mte_pkg::GAP_NONE)) begin
            gap_mid = mte_pkg::GAP_WORD;
        end else begin
            gap_mid = r_gap;
        end
        closing = r_last && (gap_mid != mte_pkg::GAP_NONE);
        n_gap   = closing ? mte_pkg::GAP_NONE : gap_mid;
        sym_n   = is_letter ? {code.len, 1'b0} : 4'd0;

        o_list.cnt = {3'd0, lead} + sym_n + {3'd0, closing};
        for (int k = 0; k < mte_pkg::MaxSegs; k++) begin
            m = 4'(k) - {3'd0, lead};
            o_list.seg[k] = '0;
            if (lead && (k == 0)) begin
                o_list.seg[k].units = (r_gap == mte_pkg::GAP_WORD) ?
                                      mte_pkg::UNITS_WORD_GAP : mte_pkg::UNITS_LETTER_GAP;
            end else if (m < sym_n) begin
                if (!m[0]) begin
                    o_list.seg[k].level = 1'b1;
                    o_list.seg[k].units = code.dash[m[2:1]] ?
                                          mte_pkg::UNITS_DASH : mte_pkg::UNITS_DOT;
                end else begin
                    o_list.seg[k].units = mte_pkg::UNITS_SYM_GAP;
                end
            end else if ((m == sym_n) && closing) begin
                o_list.seg[k].units = mte_pkg::UNITS_END_GAP;
                o_list.seg[k].fin   = 1'b1;
            end
        end
    end

    // items with no segments retire without touching the serializer
    assign take    = r_valid && ((o_list.cnt == 4'd0) || i_load_ok);
    assign o_load  = take && (o_list.cnt != 4'd0);
    assign o_ready = !r_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gap   <= mte_pkg::GAP_NONE;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
            end else if (take) begin
                r_valid <= 1'b0;
            end
            if (take) begin
                r_gap <= n_gap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_code;
            r_last <= i_is_last;
        end
    end

endmodule

`default_nettype wire

>>> src/mte_serialize.sv
`default_nettype none

module mte_serialize (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire mte_pkg::t_seg_list   i_list,
    output logic                      o_load_ok,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_segment_level,
    output logic [2:0]                o_segment_units,
    output logic                      o_message_end,
    output logic                      o_run_last
);

    logic [3:0]                        r_cnt;
    mte_pkg::t_seg [mte_pkg::MaxSegs-1:0] r_seg;
    logic                              r_out_valid;
    mte_pkg::t_seg                     r_out_seg;
    logic                              r_out_run_last;

    logic out_free;
    logic step;

    assign out_free  = !r_out_valid || i_ready;
    assign step      = (r_cnt != 4'd0) && out_free;
    assign o_load_ok = (r_cnt == 4'd0) || (step && (r_cnt == 4'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_cnt <= i_list.cnt;
            end else if (step) begin
                r_cnt <= r_cnt - 4'd1;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seg <= i_list.seg;
        end else if (step) begin
            r_seg <= {mte_pkg::t_seg'('0), r_seg[mte_pkg::MaxSegs-1:1]};
        end
        if (step) begin
            r_out_seg      <= r_seg[0];
            r_out_run_last <= (r_cnt == 4'd1);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_level = r_out_seg.level;
    assign o_segment_units = r_out_seg.units;
    assign o_message_end   = r_out_seg.fin;
    assign o_run_last      = r_out_run_last;

`include "morse_text_encoder_unit_assert.svh"

    `MTE_ASSERT_IMPL(a_load_only_when_free, i_load, o_load_ok)
    `MTE_ASSERT_IMPL(a_end_closes_run, r_out_valid && r_out_seg.fin, r_out_run_last)
    `MTE_ASSERT_IMPL(a_units_nonzero, r_out_valid, r_out_seg.units != 3'd0)
    `MTE_ASSERT_NEXT(a_drain_by_one, step && !i_load && (r_cnt > 4'd1),
                     r_cnt == $past(r_cnt) - 4'd1)

endmodule

`default_nettype wire

>>> src/morse_text_encoder_unit.sv
// Morse text encoder.
// Input channel (i_valid/o_ready): one character beat, i_char_code plus
// i_is_last marking the final character of a message. Lowercase a..z are
// keyed; space sets a word gap; anything else is dropped.
// Output channel (o_valid/i_ready): one light segment per beat, level and
// duration in 10 ms units; o_message_end flags the closing off-7 gap and
// o_run_last flags the final segment caused by a character.
// A character passes an input register, where its whole segment list is
// decoded, then a ten-entry shift stage that emits one segment per cycle
// while the receiver is ready; each segment then passes the output
// register. A character yields up to 10 segments, and the next character
// is taken while the previous list drains. Characters with no segments
// retire without being loaded into the shift stage.
// Reset (synchronous, active low) clears the pending gap and empties both
// stages. When the receiver stalls, the held segment stays on the outputs,
// the list stops shifting and o_ready drops once the input register fills.
`default_nettype none

module morse_text_encoder_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_is_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_segment_level,
    output logic [2:0]      o_segment_units,
    output logic            o_message_end,
    output logic            o_run_last
);

    logic               load_ok;
    logic               load;
    mte_pkg::t_seg_list list;

    mte_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .i_load_ok   (load_ok),
        .o_load      (load),
        .o_list      (list)
    );

    mte_serialize u_serialize (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_list          (list),
        .o_load_ok       (load_ok),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_segment_level (o_segment_level),
        .o_segment_units (o_segment_units),
        .o_message_end   (o_message_end),
        .o_run_last      (o_run_last)
    );

endmodule

`default_nettype wire
